@@ src/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants
// Operation codes, result kinds, transmit phases, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SESSION_SLOTS_DEF = 1024;
    localparam int SLOT_BITS_DEF     = 10;
    localparam int SEQ_BITS_DEF      = 24;

    localparam int OP_W    = 3;
    localparam int KIND_W  = 3;
    localparam int WIN_W   = 24;
    localparam int PPA_W   = 8;
    localparam int IP_W    = 32;
    localparam int TIPL_W  = 8;
    localparam int PTYPE_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [TIPL_W-1:0] BCAST_BYTE = 8'hff;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 24'd64;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PPA    = 1'b1;

    localparam logic [OP_W-1:0] OP_RX      = 3'd0;
    localparam logic [OP_W-1:0] OP_TX_REQ  = 3'd1;
    localparam logic [OP_W-1:0] OP_TX_FIN  = 3'd2;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd3;
    localparam logic [OP_W-1:0] OP_OPEN    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLOSE   = 3'd5;

    localparam logic [PTYPE_W-1:0] PT_DATA = 2'd0;
    localparam logic [PTYPE_W-1:0] PT_ACK  = 2'd1;
    localparam logic [PTYPE_W-1:0] PT_NACK = 2'd2;

    localparam logic [KIND_W-1:0] K_VERDICT = 3'd0;
    localparam logic [KIND_W-1:0] K_RESP    = 3'd1;
    localparam logic [KIND_W-1:0] K_TIMER   = 3'd2;
    localparam logic [KIND_W-1:0] K_RETX    = 3'd3;
    localparam logic [KIND_W-1:0] K_GRANT   = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HELD = 2'd1,
        PH_WAIT = 2'd2
    } tx_phase_t;

    // Controller: IDLE takes an item, READ reads the held slot and session
    // entry, EXEC computes and writes back, EMIT drains results one by one.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EXEC = 2'd2,
        ST_EMIT = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic results_left;
    } dp_status_t;

endpackage

@@ src/gbn_if.sv @@
// ----------------------------------------------------------------------------
// gbn_in_if / gbn_out_if: valid-ready channels
// Input event channel and result channel with their payload fields.
// ----------------------------------------------------------------------------
interface gbn_in_if #(
    parameter int SLOT_BITS = gbn_pkg::SLOT_BITS_DEF,
    parameter int SEQ_BITS  = gbn_pkg::SEQ_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [gbn_pkg::OP_W-1:0]     operation;
    logic [SLOT_BITS-1:0]         local_slot;
    logic [SLOT_BITS-1:0]         peer_slot;
    logic [gbn_pkg::PTYPE_W-1:0]  pkt_type;
    logic [SEQ_BITS-1:0]          seq_num;
    logic [gbn_pkg::IP_W-1:0]     sender_ip;
    logic [gbn_pkg::TIPL_W-1:0]   target_ip_low;

    modport source (output valid, operation, local_slot, peer_slot, pkt_type,
                    seq_num, sender_ip, target_ip_low, input ready);
    modport sink (input valid, operation, local_slot, peer_slot, pkt_type,
                  seq_num, sender_ip, target_ip_low, output ready);
endinterface

interface gbn_out_if #(
    parameter int SLOT_BITS = gbn_pkg::SLOT_BITS_DEF,
    parameter int SEQ_BITS  = gbn_pkg::SEQ_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [gbn_pkg::KIND_W-1:0] result_kind;
    logic                       deliver;
    logic                       resp_is_nack;
    logic                       timer_stop;
    logic [gbn_pkg::IP_W-1:0]   resp_ip;
    logic [SLOT_BITS-1:0]       slot_out;
    logic [SLOT_BITS-1:0]       peer_slot_out;
    logic [SEQ_BITS-1:0]        seq_first;
    logic [SEQ_BITS-1:0]        seq_final;
    logic                       last;

    modport source (output valid, result_kind, deliver, resp_is_nack, timer_stop,
                    resp_ip, slot_out, peer_slot_out, seq_first, seq_final, last,
                    input ready);
    modport sink (input valid, result_kind, deliver, resp_is_nack, timer_stop,
                  resp_ip, slot_out, peer_slot_out, seq_first, seq_final, last,
                  output ready);
endinterface

@@ src/go_back_n_session_state_table.sv @@
// ----------------------------------------------------------------------------
// go_back_n_session_state_table: per-session go-back-N state
// Top level joining the controller, the session datapath and the channels.
// ----------------------------------------------------------------------------
// Each accepted event reads its session entry and the held slot's entry in
// READ, executes with write-back in EXEC, and then drains its result
// transactions one by one in EMIT, which it enters even when the event yields
// none; the controller then returns to IDLE, where it takes the next event. No
// new event is taken until the results of the last one have drained, and the
// result side can hold the drain. The read-modify-write of the session RAM and
// the serial result drain set how fast events go through. After reset the
// block clears its session RAMs, one entry a cycle, before it accepts the
// first event; configuration writes are taken at any time meanwhile. A held
// transmit request is rechecked at the end of every event and its grant
// follows that event's other results, marked last.
module go_back_n_session_state_table #(
    parameter int SESSION_SLOTS = gbn_pkg::SESSION_SLOTS_DEF,
    parameter int SLOT_BITS     = gbn_pkg::SLOT_BITS_DEF,
    parameter int SEQ_BITS      = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
    gbn_in_if.sink                         in_ch,
    gbn_out_if.source                      out_ch
);
    gbn_pkg::ctrl_cmd_t   cmd;
    gbn_pkg::dp_status_t  status;
    gbn_pkg::ctrl_state_t state;
    logic                 clear_busy;

    gbn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .out_ready(out_ch.ready),
        .clear_busy(clear_busy), .status(status), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .cmd(cmd), .state(state));

    gbn_dp #(.SESSION_SLOTS(SESSION_SLOTS), .SLOT_BITS(SLOT_BITS),
             .SEQ_BITS(SEQ_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .i_op(in_ch.operation), .i_slot(in_ch.local_slot), .i_peer(in_ch.peer_slot),
        .i_type(in_ch.pkt_type), .i_seq(in_ch.seq_num), .i_ip(in_ch.sender_ip),
        .i_tipl(in_ch.target_ip_low), .status(status), .clear_busy(clear_busy),
        .o_kind(out_ch.result_kind), .o_deliver(out_ch.deliver),
        .o_nack(out_ch.resp_is_nack), .o_stop(out_ch.timer_stop),
        .o_ip(out_ch.resp_ip), .o_slot(out_ch.slot_out),
        .o_peer(out_ch.peer_slot_out), .o_first(out_ch.seq_first),
        .o_final(out_ch.seq_final), .o_last(out_ch.last));

`ifndef SYNTHESIS
    // No event is taken while results of the previous one are pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input accepted while results pending");

    // Execution always follows the read cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == gbn_pkg::ST_READ) |=> (state == gbn_pkg::ST_EXEC))
        else $error("controller skipped execute");

    // Nothing is accepted during the RAM clearing sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !in_ch.ready)
        else $error("input accepted during clear");
`endif
endmodule

@@ src/gbn_ram.sv @@
// ----------------------------------------------------------------------------
// gbn_ram: generic single-port RAM
// One address per cycle, read and optionally written; registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ src/gbn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbn_ctrl: sequencing controller
// Walks each item through read, execute and result drain.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_ready,
    input  logic                 clear_busy,
    input  gbn_pkg::dp_status_t  status,
    output logic                 in_ready,
    output logic                 out_valid,
    output gbn_pkg::ctrl_cmd_t   cmd,
    output gbn_pkg::ctrl_state_t state
);
    gbn_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (in_valid && !clear_busy)
                begin
                    state_next = gbn_pkg::ST_READ;
                end
            end
            gbn_pkg::ST_READ: state_next = gbn_pkg::ST_EXEC;
            gbn_pkg::ST_EXEC: state_next = gbn_pkg::ST_EMIT;
            gbn_pkg::ST_EMIT:
            begin
                if (!status.results_left)
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            default: state_next = gbn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                in_ready    = !clear_busy;
                cmd.capture = in_valid && !clear_busy;
            end
            gbn_pkg::ST_EXEC: cmd.exec = 1'b1;
            gbn_pkg::ST_EMIT:
            begin
                out_valid = status.results_left;
                cmd.pop   = status.results_left && out_ready;
            end
            default: ;
        endcase
    end

    assign state = state_reg;
endmodule

@@ src/gbn_dp.sv @@
// ----------------------------------------------------------------------------
// gbn_dp: session datapath
// Session RAMs, transmit-path registers, event logic and the result queue.
// ----------------------------------------------------------------------------
module gbn_dp #(
    parameter int SESSION_SLOTS = gbn_pkg::SESSION_SLOTS_DEF,
    parameter int SLOT_BITS     = gbn_pkg::SLOT_BITS_DEF,
    parameter int SEQ_BITS      = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gbn_pkg::ctrl_cmd_t            cmd,
    input  logic                          cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [gbn_pkg::OP_W-1:0]      i_op,
    input  logic [SLOT_BITS-1:0]          i_slot,
    input  logic [SLOT_BITS-1:0]          i_peer,
    input  logic [gbn_pkg::PTYPE_W-1:0]   i_type,
    input  logic [SEQ_BITS-1:0]           i_seq,
    input  logic [gbn_pkg::IP_W-1:0]      i_ip,
    input  logic [gbn_pkg::TIPL_W-1:0]    i_tipl,
    output gbn_pkg::dp_status_t           status,
    output logic                          clear_busy,
    output logic [gbn_pkg::KIND_W-1:0]    o_kind,
    output logic                          o_deliver,
    output logic                          o_nack,
    output logic                          o_stop,
    output logic [gbn_pkg::IP_W-1:0]      o_ip,
    output logic [SLOT_BITS-1:0]          o_slot,
    output logic [SLOT_BITS-1:0]          o_peer,
    output logic [SEQ_BITS-1:0]           o_first,
    output logic [SEQ_BITS-1:0]           o_final,
    output logic                          o_last
);
    localparam int AW = $clog2(SESSION_SLOTS);
    // ack_enabled, expected, acked, sent, countdown in one word
    localparam int EW = 1 + 3 * SEQ_BITS + gbn_pkg::PPA_W;
    localparam int WIDE = ((SEQ_BITS > gbn_pkg::WIN_W) ? SEQ_BITS : gbn_pkg::WIN_W) + 1;
    localparam int RW = gbn_pkg::KIND_W + 3 + gbn_pkg::IP_W + 2 * SLOT_BITS
                        + 2 * SEQ_BITS;

    typedef struct packed {
        logic [gbn_pkg::KIND_W-1:0] kind;
        logic                       dlv;
        logic                       nack;
        logic                       stop;
        logic [gbn_pkg::IP_W-1:0]   ip;
        logic [SLOT_BITS-1:0]       slot;
        logic [SLOT_BITS-1:0]       peer;
        logic [SEQ_BITS-1:0]        first;
        logic [SEQ_BITS-1:0]        fin;
    } res_t;

    // configuration
    logic [gbn_pkg::WIN_W-1:0] window_reg;
    logic [gbn_pkg::PPA_W-1:0] ppa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= gbn_pkg::WINDOW_RESET;
            ppa_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gbn_pkg::REG_WINDOW: window_reg <= cfg_data[gbn_pkg::WIN_W-1:0];
                gbn_pkg::REG_PPA:    ppa_reg    <= cfg_data[gbn_pkg::PPA_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [gbn_pkg::OP_W-1:0]    op_reg;
    logic [SLOT_BITS-1:0]        slot_reg, peer_reg;
    logic [gbn_pkg::PTYPE_W-1:0] type_reg;
    logic [SEQ_BITS-1:0]         seq_reg;
    logic [gbn_pkg::IP_W-1:0]    ip_reg;
    logic [gbn_pkg::TIPL_W-1:0]  tipl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= i_op;
            slot_reg <= i_slot;
            peer_reg <= i_peer;
            type_reg <= i_type;
            seq_reg  <= i_seq;
            ip_reg   <= i_ip;
            tipl_reg <= i_tipl;
        end
    end

    // transmit path
    gbn_pkg::tx_phase_t   phase_reg;
    logic [SLOT_BITS-1:0] txs_reg;
    logic [SEQ_BITS-1:0]  txa_reg, txsn_reg;
    gbn_pkg::tx_phase_t   phase_next;
    logic [SLOT_BITS-1:0] txs_next;
    logic [SEQ_BITS-1:0]  txa_next, txsn_next;

    // clearing sweep after reset, one entry per cycle
    logic [AW:0] clr_reg;
    assign clear_busy = !clr_reg[AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clear_busy)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Two session RAMs: one for the event's slot, one for the held slot.
    // Both are written with the same data so they stay identical.
    logic          we_a, we_b;
    logic [AW-1:0] addr_a, addr_b;
    logic [EW-1:0] wd_a, wd_b, rd_a, rd_b;
    logic [AW-1:0] ia, ib;

    assign ia = AW'(32'(slot_reg) % SESSION_SLOTS);
    assign ib = AW'(32'(txs_reg) % SESSION_SLOTS);

    gbn_ram #(.WIDTH(EW), .DEPTH(SESSION_SLOTS)) u_ram_a (
        .clk(clk), .we(we_a), .addr(addr_a), .wdata(wd_a), .rdata(rd_a));
    gbn_ram #(.WIDTH(EW), .DEPTH(SESSION_SLOTS)) u_ram_b (
        .clk(clk), .we(we_b), .addr(addr_b), .wdata(wd_b), .rdata(rd_b));

    // execute stage
    logic                       en_a;
    logic [SEQ_BITS-1:0]        ex_a, ak_a, sn_a;
    logic [gbn_pkg::PPA_W-1:0]  cd_a;
    logic [SEQ_BITS-1:0]        ak_b;
    logic                       en_n;
    logic [SEQ_BITS-1:0]        ex_n, ak_n, sn_n;
    logic [gbn_pkg::PPA_W-1:0]  cd_n;
    logic                       wr_a, wr_b, same;
    logic [SEQ_BITS-1:0]        sn_b_n, pk_ak, seq1;
    res_t                       r0, r1, r2;
    logic [1:0]                 cnt;

    assign {en_a, ex_a, ak_a, sn_a, cd_a} = rd_a;
    assign ak_b = rd_b[SEQ_BITS + SEQ_BITS + gbn_pkg::PPA_W - 1 -: SEQ_BITS];
    assign same = (ia == ib);
    assign seq1 = seq_reg + 1'b1;

    function automatic res_t mk(input logic [gbn_pkg::KIND_W-1:0] k,
                                input logic [SLOT_BITS-1:0] s);
        res_t r;
        r      = '0;
        r.kind = k;
        r.slot = s;
        return r;
    endfunction

    always_comb
    begin
        en_n = en_a; ex_n = ex_a; ak_n = ak_a; sn_n = sn_a; cd_n = cd_a;
        wr_a = 1'b0;
        wr_b = 1'b0;
        sn_b_n = '0;
        phase_next = phase_reg; txs_next = txs_reg;
        txa_next = txa_reg; txsn_next = txsn_reg;
        r0 = '0; r1 = '0; r2 = '0;
        cnt = 2'd0;
        pk_ak = '0;
        case (op_reg)
            gbn_pkg::OP_RX:
            begin
                r0 = mk(gbn_pkg::K_VERDICT, slot_reg);
                cnt = 2'd1;
                if (tipl_reg == gbn_pkg::BCAST_BYTE)
                begin
                end
                else if (slot_reg == '0 || peer_reg == '0)
                begin
                    r0.dlv = (type_reg == gbn_pkg::PT_DATA);
                end
                else if (type_reg == gbn_pkg::PT_DATA)
                begin
                    r1 = mk(gbn_pkg::K_RESP, slot_reg);
                    r1.ip = ip_reg;
                    r1.peer = peer_reg;
                    r1.first = ex_a - 1'b1;
                    if (seq_reg == ex_a)
                    begin
                        wr_a = 1'b1;
                        ex_n = ex_a + 1'b1;
                        en_n = 1'b1;
                        r0.dlv = 1'b1;
                        if (cd_a == '0)
                        begin
                            r1.first = ex_a;
                            cnt = 2'd2;
                            cd_n = ppa_reg;
                        end
                        else
                        begin
                            cd_n = cd_a - 1'b1;
                        end
                    end
                    else if (en_a)
                    begin
                        cnt = 2'd2;
                        if (seq_reg > ex_a)
                        begin
                            wr_a = 1'b1;
                            en_n = 1'b0;
                            r1.nack = 1'b1;
                        end
                    end
                end
                else if (type_reg == gbn_pkg::PT_ACK || type_reg == gbn_pkg::PT_NACK)
                begin
                    r1 = mk(gbn_pkg::K_TIMER, slot_reg);
                    if (seq_reg > ak_a)
                    begin
                        wr_a = 1'b1;
                        ak_n = seq_reg;
                        cnt = 2'd2;
                        if (seq_reg == sn_a)
                        begin
                            r1.stop = 1'b1;
                        end
                        else if (type_reg == gbn_pkg::PT_NACK)
                        begin
                            r1.kind = gbn_pkg::K_RETX;
                            r1.first = seq1;
                            r1.fin = sn_a;
                        end
                    end
                    else if (seq_reg == ak_a && type_reg == gbn_pkg::PT_NACK)
                    begin
                        cnt = 2'd2;
                        r1.kind = gbn_pkg::K_RETX;
                        r1.first = seq1;
                        r1.fin = sn_a;
                    end
                end
            end
            gbn_pkg::OP_TX_REQ:
            begin
                if (phase_reg == gbn_pkg::PH_IDLE)
                begin
                    txs_next = slot_reg;
                    txsn_next = sn_a;
                    phase_next = gbn_pkg::PH_HELD;
                end
            end
            gbn_pkg::OP_TX_FIN:
            begin
                if (phase_reg == gbn_pkg::PH_WAIT)
                begin
                    if (txa_reg == txsn_reg)
                    begin
                        r0 = mk(gbn_pkg::K_TIMER, txs_reg);
                        cnt = 2'd1;
                    end
                    phase_next = gbn_pkg::PH_IDLE;
                end
            end
            gbn_pkg::OP_TIMEOUT:
            begin
                r0 = mk(gbn_pkg::K_RETX, slot_reg);
                r0.first = ak_a + 1'b1;
                r0.fin = sn_a;
                cnt = 2'd1;
            end
            gbn_pkg::OP_OPEN:
            begin
                wr_a = 1'b1;
                en_n = 1'b1; ak_n = '0; sn_n = '0; ex_n = SEQ_BITS'(1); cd_n = '0;
            end
            gbn_pkg::OP_CLOSE:
            begin
                wr_a = 1'b1;
                ex_n = '0;
            end
            default: ;
        endcase

        // Recheck a held request: event write-back to the same slot wins.
        if (phase_next == gbn_pkg::PH_HELD)
        begin
            if (phase_reg == gbn_pkg::PH_HELD)
            begin
                pk_ak = (same && wr_a) ? ak_n : ak_b;
            end
            else
            begin
                pk_ak = ak_a;
            end
            if ((WIDE'(pk_ak) + WIDE'(window_reg)) > WIDE'(txsn_next))
            begin
                sn_b_n = txsn_next + 1'b1;
                txa_next = pk_ak;
                phase_next = gbn_pkg::PH_WAIT;
                if (cnt == 2'd0)
                begin
                    r0 = mk(gbn_pkg::K_GRANT, txs_next);
                    r0.first = sn_b_n;
                end
                else if (cnt == 2'd1)
                begin
                    r1 = mk(gbn_pkg::K_GRANT, txs_next);
                    r1.first = sn_b_n;
                end
                else
                begin
                    r2 = mk(gbn_pkg::K_GRANT, txs_next);
                    r2.first = sn_b_n;
                end
                cnt = cnt + 1'b1;
                wr_b = 1'b1;
            end
        end
    end

    // The granted slot's write merges with any event write to that slot.
    logic [EW-1:0] ent_a_n, ent_b_n;
    logic [AW-1:0] gslot;
    assign gslot = (phase_reg == gbn_pkg::PH_HELD) ? ib : ia;

    always_comb
    begin
        ent_a_n = {en_n, ex_n, ak_n, sn_n, cd_n};
        if (wr_b && gslot == ia)
        begin
            ent_a_n = {en_n, ex_n, ak_n, sn_b_n, cd_n};
        end
        ent_b_n = rd_b;
        ent_b_n[SEQ_BITS + gbn_pkg::PPA_W - 1 -: SEQ_BITS] = sn_b_n;
    end

    // A grant for a slot other than the event's is written in the cycle after execute,
    // while the first result drains, so the event's own write is kept.
    logic          dw_pend_reg, dw_pend_next;
    logic [AW-1:0] dw_addr_reg;
    logic [EW-1:0] dw_data_reg;

    assign dw_pend_next = cmd.exec && wr_b && (gslot != ia);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dw_pend_reg <= 1'b0;
        end
        else
        begin
            dw_pend_reg <= dw_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dw_pend_next)
        begin
            dw_addr_reg <= gslot;
            dw_data_reg <= ent_b_n;
        end
    end

    always_comb
    begin
        we_a = 1'b0; we_b = 1'b0;
        addr_a = ia; addr_b = ib;
        wd_a = ent_a_n; wd_b = ent_a_n;
        if (clear_busy)
        begin
            we_a = 1'b1; we_b = 1'b1;
            addr_a = clr_reg[AW-1:0]; addr_b = clr_reg[AW-1:0];
            wd_a = '0; wd_b = '0;
        end
        else if (cmd.exec)
        begin
            if (wr_a || (wr_b && gslot == ia))
            begin
                we_a = 1'b1; we_b = 1'b1;
                addr_b = ia;
            end
        end
        else if (dw_pend_reg)
        begin
            we_a = 1'b1; we_b = 1'b1;
            addr_a = dw_addr_reg; addr_b = dw_addr_reg;
            wd_a = dw_data_reg; wd_b = dw_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gbn_pkg::PH_IDLE;
            txs_reg   <= '0;
            txa_reg   <= '0;
            txsn_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            phase_reg <= phase_next;
            txs_reg   <= txs_next;
            txa_reg   <= txa_next;
            txsn_reg  <= txsn_next;
        end
    end

    // Result queue: up to three results, shifted out from the head.
    res_t       q_reg [3];
    logic [1:0] n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (cmd.exec)
        begin
            n_reg <= cnt;
        end
        else if (cmd.pop)
        begin
            n_reg <= n_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            q_reg[0] <= r0; q_reg[1] <= r1; q_reg[2] <= r2;
        end
        else if (cmd.pop)
        begin
            q_reg[0] <= q_reg[1]; q_reg[1] <= q_reg[2];
        end
    end

    assign status.results_left = (n_reg != 2'd0);
    assign {o_kind, o_deliver, o_nack, o_stop, o_ip, o_slot, o_peer, o_first,
            o_final} = RW'(q_reg[0]);
    assign o_last = (n_reg == 2'd1);
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for go_back_n_session_state_table
// Drives session events through the input channel, mirrors the session table
// in a behavioral predictor and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;
    import gbn_pkg::*;

    localparam int SLOTS = SESSION_SLOTS_DEF;

    // Unknown operation codes; the block must ignore them.
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
    localparam logic [PTYPE_W-1:0] PT_OTHER = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [9:0]         slot;
        logic [9:0]         peer;
        logic [PTYPE_W-1:0] ptype;
        logic [23:0]        seq;
        logic [IP_W-1:0]    ip;
        logic [TIPL_W-1:0]  tgt;
    } session_event_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              deliver;
        logic              is_nack;
        logic              stop;
        logic [IP_W-1:0]   ip;
        logic [9:0]        slot;
        logic [9:0]        peer;
        logic [23:0]       first;
        logic [23:0]       fin_seq;
        logic              last;
    } session_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbn_in_if  in_if ();
    gbn_out_if out_if ();

    go_back_n_session_state_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Mirror of the session table and of the transmit path.
    // ------------------------------------------------------------------------
    logic [23:0] win_size;
    logic [7:0]  acks_coalesced;
    logic        mir_ack_en   [SLOTS];
    logic [23:0] mir_expected [SLOTS];
    logic [23:0] mir_acked    [SLOTS];
    logic [23:0] mir_sent     [SLOTS];
    logic [7:0]  mir_countdown[SLOTS];
    tx_phase_t   mir_phase;
    logic [9:0]  mir_tx_slot;
    logic [23:0] mir_tx_acked;
    logic [23:0] mir_tx_sent;

    // Results the block still owes, oldest first, and those of the event at hand.
    session_result_t expected_results[$];
    session_result_t event_results[$];

    int mismatches = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_left = 0;

    function automatic void add_result(logic [KIND_W-1:0] kind, logic dlv, logic nack,
                                       logic stop, logic [31:0] ip, logic [9:0] slot,
                                       logic [9:0] peer, logic [23:0] first,
                                       logic [23:0] fin_seq);
        session_result_t r;
        r = '{kind, dlv, nack, stop, ip, slot, peer, first, fin_seq, 1'b0};
        event_results.push_back(r);
    endfunction

    function automatic void predict_rx(session_event_t e);
        logic [23:0] expt;
        logic [23:0] ackd;
        logic [23:0] sent;
        expt = mir_expected[e.slot];
        ackd = mir_acked[e.slot];
        sent = mir_sent[e.slot];
        if (e.tgt == BCAST_BYTE)
            add_result(K_VERDICT, 0, 0, 0, 0, e.slot, 0, 0, 0);
        else if (e.slot == 0 || e.peer == 0)
            add_result(K_VERDICT, e.ptype == PT_DATA, 0, 0, 0, e.slot, 0, 0, 0);
        else if (e.ptype == PT_DATA)
        begin
            if (e.seq == expt)
            begin
                // In-order data: deliver, and acknowledge unless coalescing.
                mir_expected[e.slot] = expt + 24'd1;
                mir_ack_en[e.slot] = 1'b1;
                add_result(K_VERDICT, 1, 0, 0, 0, e.slot, 0, 0, 0);
                if (mir_countdown[e.slot] == 0)
                begin
                    add_result(K_RESP, 0, 0, 0, e.ip, e.slot, e.peer, expt, 0);
                    mir_countdown[e.slot] = acks_coalesced;
                end
                else
                    mir_countdown[e.slot] = mir_countdown[e.slot] - 8'd1;
            end
            else
            begin
                add_result(K_VERDICT, 0, 0, 0, 0, e.slot, 0, 0, 0);
                if (mir_ack_en[e.slot])
                begin
                    // A gap sends one NACK and mutes responses; a duplicate re-ACKs.
                    if (e.seq > expt)
                    begin
                        mir_ack_en[e.slot] = 1'b0;
                        add_result(K_RESP, 0, 1, 0, e.ip, e.slot, e.peer, expt - 24'd1, 0);
                    end
                    else
                        add_result(K_RESP, 0, 0, 0, e.ip, e.slot, e.peer, expt - 24'd1, 0);
                end
            end
        end
        else
        begin
            add_result(K_VERDICT, 0, 0, 0, 0, e.slot, 0, 0, 0);
            if (e.ptype == PT_ACK || e.ptype == PT_NACK)
            begin
                if (e.seq > ackd)
                begin
                    mir_acked[e.slot] = e.seq;
                    if (e.seq == sent)
                        add_result(K_TIMER, 0, 0, 1, 0, e.slot, 0, 0, 0);
                    else if (e.ptype == PT_ACK)
                        add_result(K_TIMER, 0, 0, 0, 0, e.slot, 0, 0, 0);
                    else
                        add_result(K_RETX, 0, 0, 0, 0, e.slot, 0, e.seq + 24'd1, sent);
                end
                else if (e.seq == ackd && e.ptype == PT_NACK)
                    add_result(K_RETX, 0, 0, 0, 0, e.slot, 0, e.seq + 24'd1, sent);
            end
        end
    endfunction

    function automatic void predict_session_event(session_event_t e);
        logic [24:0] reach;
        event_results.delete();
        case (e.op)
            OP_RX: predict_rx(e);
            OP_TX_REQ:
                if (mir_phase == PH_IDLE)
                begin
                    mir_tx_slot = e.slot;
                    mir_tx_sent = mir_sent[e.slot];
                    mir_phase = PH_HELD;
                end
            OP_TX_FIN:
                if (mir_phase == PH_WAIT)
                begin
                    if (mir_tx_acked == mir_tx_sent)
                        add_result(K_TIMER, 0, 0, 0, 0, mir_tx_slot, 0, 0, 0);
                    mir_phase = PH_IDLE;
                end
            OP_TIMEOUT:
                add_result(K_RETX, 0, 0, 0, 0, e.slot, 0, mir_acked[e.slot] + 24'd1,
                           mir_sent[e.slot]);
            OP_OPEN:
            begin
                mir_ack_en[e.slot] = 1'b1;
                mir_acked[e.slot] = '0;
                mir_sent[e.slot] = '0;
                mir_expected[e.slot] = 24'd1;
                mir_countdown[e.slot] = '0;
            end
            OP_CLOSE: mir_expected[e.slot] = '0;
            default: ;
        endcase
        // A held request is retried after every event; the window compare is wide.
        if (mir_phase == PH_HELD)
        begin
            reach = {1'b0, mir_acked[mir_tx_slot]} + {1'b0, win_size};
            if (reach > {1'b0, mir_tx_sent})
            begin
                mir_sent[mir_tx_slot] = mir_tx_sent + 24'd1;
                mir_tx_acked = mir_acked[mir_tx_slot];
                mir_phase = PH_WAIT;
                add_result(K_GRANT, 0, 0, 0, 0, mir_tx_slot, 0, mir_tx_sent + 24'd1, 0);
            end
        end
        if (event_results.size() > 0)
            event_results[event_results.size() - 1].last = 1'b1;
        foreach (event_results[k])
            expected_results.push_back(event_results[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------------
    // Sends one event; returns once the block has accepted the transaction.
    task automatic send_event(session_event_t e);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= e.op;
        in_if.local_slot    <= e.slot;
        in_if.peer_slot     <= e.peer;
        in_if.pkt_type      <= e.ptype;
        in_if.seq_num       <= e.seq;
        in_if.sender_ip     <= e.ip;
        in_if.target_ip_low <= e.tgt;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_session_event(e);
    endtask

    task automatic stop_sending();
        in_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted result has arrived, then lets the block
    // finish an event that produced nothing.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW)
            win_size = value;
        else
            acks_coalesced = value[7:0];
        @(posedge clk);
    endtask

    // The receiver idles at random, or holds off entirely while hold_left runs.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        session_result_t got;
        session_result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = '{out_if.result_kind, out_if.deliver, out_if.resp_is_nack,
                    out_if.timer_stop, out_if.resp_ip, out_if.slot_out,
                    out_if.peer_slot_out, out_if.seq_first, out_if.seq_final,
                    out_if.last};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event generation
    // ------------------------------------------------------------------------
    function automatic session_event_t make_event(logic [OP_W-1:0] op, int slot, int peer,
                                                  logic [1:0] ptype, logic [23:0] seq);
        session_event_t e;
        e.op = op;
        e.slot = 10'(slot);
        e.peer = 10'(peer);
        e.ptype = ptype;
        e.seq = seq;
        e.ip = $urandom;
        e.tgt = TIPL_W'($urandom_range(254));
        return e;
    endfunction

    // Mostly well-formed traffic on a handful of sessions, guided by the
    // mirror so that in-order data and meaningful ACKs dominate.
    function automatic session_event_t random_event();
        session_event_t e;
        int pick;
        int s;
        s = int'($urandom_range(4, 1));
        pick = int'($urandom_range(99));
        e = make_event(OP_RX, s, int'($urandom_range(1023, 1)), PT_DATA, 24'd0);
        if (pick < 8)
        begin
            // Noise: anything the fields allow.
            e.op = OP_W'($urandom_range(7));
            e.slot = 10'($urandom);
            e.peer = 10'($urandom);
            e.ptype = PTYPE_W'($urandom);
            e.seq = 24'($urandom);
            e.tgt = ($urandom_range(3) == 0) ? BCAST_BYTE : TIPL_W'($urandom);
        end
        else if (pick < 40)
        begin
            case ($urandom_range(9))
                0: e.seq = mir_expected[s] + 24'($urandom_range(5, 1));
                1: e.seq = mir_expected[s] - 24'd1;
                2: e.seq = 24'($urandom);
                default: e.seq = mir_expected[s];
            endcase
        end
        else if (pick < 60)
        begin
            e.ptype = $urandom_range(1) ? PT_ACK : PT_NACK;
            e.seq = 24'($urandom_range(mir_sent[s], mir_acked[s]));
            if ($urandom_range(9) == 0)
                e.seq = 24'($urandom);
        end
        else if (pick < 72)
            e.op = OP_TX_REQ;
        else if (pick < 84)
        begin
            e.op = OP_TX_FIN;
            e.slot = mir_tx_slot;
        end
        else if (pick < 89)
            e.op = OP_TIMEOUT;
        else if (pick < 95)
            e.op = OP_OPEN;
        else if (pick < 97)
            e.op = OP_CLOSE;
        else
        begin
            e.peer = $urandom_range(1) ? 10'd0 : e.peer;
            e.slot = (e.peer == 0) ? e.slot : 10'd0;
            e.ptype = PTYPE_W'($urandom);
        end
        if (e.op == OP_RX && $urandom_range(24) == 0)
            e.tgt = BCAST_BYTE;
        return e;
    endfunction

    task automatic run_random(int count);
        repeat (count)
            send_event(random_event());
        stop_sending();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Every operation and each special case once, with extreme field values.
    task automatic test_directed();
        session_event_t e;
        send_event(make_event(OP_OPEN, 1, 0, PT_DATA, 0));
        send_event(make_event(OP_RX, 1, 7, PT_DATA, 24'd1));      // in order, ACK
        send_event(make_event(OP_RX, 1, 7, PT_DATA, 24'd1));      // duplicate
        send_event(make_event(OP_RX, 1, 7, PT_DATA, 24'd9));      // gap, NACK
        send_event(make_event(OP_RX, 1, 7, PT_DATA, 24'd9));      // muted after NACK
        e = make_event(OP_RX, 1, 7, PT_DATA, 24'd2);
        e.tgt = BCAST_BYTE;
        send_event(e);                                            // broadcast drop
        send_event(make_event(OP_RX, 0, 7, PT_DATA, 24'd2));      // slot zero data
        send_event(make_event(OP_RX, 1, 0, PT_ACK, 24'd2));       // peer zero ack
        send_event(make_event(OP_RX, 1, 7, PT_OTHER, 24'd2));     // other type
        send_event(make_event(OP_TX_REQ, 1, 0, PT_DATA, 0));      // granted
        send_event(make_event(OP_TX_REQ, 2, 0, PT_DATA, 0));      // busy, ignored
        send_event(make_event(OP_TX_FIN, 1, 0, PT_DATA, 0));      // timer restart
        send_event(make_event(OP_TX_FIN, 1, 0, PT_DATA, 0));      // stray finish
        send_event(make_event(OP_TIMEOUT, 1, 0, PT_DATA, 0));
        send_event(make_event(OP_RX, 1, 7, PT_NACK, 24'd0));      // retransmit all
        send_event(make_event(OP_RX, 1, 7, PT_ACK, 24'd1));       // timer stop
        send_event(make_event(OP_UNUSED_A, 1, 0, PT_DATA, 0));
        send_event(make_event(OP_UNUSED_B, 1, 0, PT_DATA, 0));
        send_event(make_event(OP_CLOSE, 1, 0, PT_DATA, 0));
        send_event(make_event(OP_RX, 1, 7, PT_DATA, 24'd0));      // closed session
        send_event(make_event(OP_OPEN, 1023, 0, PT_DATA, 0));
        e = make_event(OP_RX, 1023, 1023, PT_DATA, 24'hffffff);
        e.ip = 32'hffffffff;
        e.tgt = 8'hfe;
        send_event(e);                                            // far gap, max fields
        e = make_event(OP_RX, 1023, 1023, PT_ACK, 24'hffffff);
        e.ip = 32'h0;
        e.tgt = 8'h00;
        send_event(e);                                            // ack beyond sent
        send_event(make_event(OP_TIMEOUT, 1023, 0, PT_DATA, 0));  // wrapping start
        stop_sending();
        wait_drained();
    endtask

    // Window of one: a second request is held until an ACK opens the window.
    task automatic test_narrow_window();
        write_reg(REG_WINDOW, 24'd1);
        write_reg(REG_PPA, 24'd0);
        send_event(make_event(OP_OPEN, 2, 0, PT_DATA, 0));
        send_event(make_event(OP_TX_REQ, 2, 0, PT_DATA, 0));
        send_event(make_event(OP_TX_FIN, 2, 0, PT_DATA, 0));
        send_event(make_event(OP_TX_REQ, 2, 0, PT_DATA, 0));      // held
        send_event(make_event(OP_RX, 2, 5, PT_DATA, 24'd1));
        send_event(make_event(OP_RX, 2, 5, PT_ACK, 24'd1));       // releases grant
        send_event(make_event(OP_TX_FIN, 2, 0, PT_DATA, 0));
        run_random(60);
        wait_drained();
    endtask

    // Widest window and the most ACK coalescing, then a window of three with light coalescing.
    task automatic test_wide_window_coalescing();
        write_reg(REG_WINDOW, 24'hffffff);
        write_reg(REG_PPA, 24'd255);
        run_random(50);
        wait_drained();
        write_reg(REG_WINDOW, 24'd3);
        write_reg(REG_PPA, 24'd2);
        run_random(60);
        wait_drained();
        write_reg(REG_WINDOW, WINDOW_RESET);
        write_reg(REG_PPA, 24'd1);
    endtask

    // Random traffic under each mix of sender and receiver idling.
    task automatic test_idle_mixes();
        in_idle_pct = 25;
        out_idle_pct = 49;
        run_random(100);
        in_idle_pct = 49;
        out_idle_pct = 25;
        run_random(100);
        in_idle_pct = 0;
        out_idle_pct = 0;
        run_random(100);
        wait_drained();
    endtask

    // The receiver stalls for a long stretch so the block backs up into its
    // input; afterwards the sender pauses until every result has come back.
    task automatic test_backpressure();
        hold_left = 400;
        run_random(40);
        wait_drained();
        run_random(20);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_WINDOW;
        cfg_data <= '0;
        in_if.valid <= 1'b0;
        in_if.operation <= OP_RX;
        in_if.local_slot <= '0;
        in_if.peer_slot <= '0;
        in_if.pkt_type <= PT_DATA;
        in_if.seq_num <= '0;
        in_if.sender_ip <= '0;
        in_if.target_ip_low <= '0;
        win_size = WINDOW_RESET;
        acks_coalesced = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            mir_ack_en[k] = 1'b0;
            mir_expected[k] = '0;
            mir_acked[k] = '0;
            mir_sent[k] = '0;
            mir_countdown[k] = '0;
        end
        mir_phase = PH_IDLE;
        mir_tx_slot = '0;
        mir_tx_acked = '0;
        mir_tx_sent = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_narrow_window();
        test_wide_window_coalescing();
        test_idle_mixes();
        test_backpressure();

        wait_drained();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("go_back_n_session_state_table regression: pass");
        else
            $display("go_back_n_session_state_table regression: fail");
        $finish;
    end

    // Watchdog: generous against the slowest legal run, including the
    // table clear after reset and the long receiver stall.
    initial
    begin
        #4ms;
        $display("go_back_n_session_state_table regression: fail");
        $finish;
    end

endmodule
